/* hw/rtl/hsv_pkg.sv */
// Shared widths, constants and stage types of the HSV to RGB converter.
package hsv_pkg;

  localparam int HUE_W     = 9;
  localparam int PCT_W     = 7;
  localparam int LVL_W     = 8;
  localparam int FR_W      = 6;
  localparam int SEC_W     = 3;
  localparam int TERM_W    = 13;
  localparam int NUM_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam int SECTOR_DEG   = 60;
  localparam int SECTOR_COUNT = 6;
  localparam int PCT_FULL     = 100;
  localparam int TERM_FULL    = PCT_FULL * SECTOR_DEG;
  // Number of sector boundaries that a hue of HUE_W bits can pass.
  localparam int HUE_STEPS    = ((2 ** HUE_W) - 1) / SECTOR_DEG;

  // floor(255 * n / 600000) == (n * LEVEL_MUL) >> LEVEL_SHIFT for n <= 600000.
  localparam int MUL_W       = 28;
  localparam int PROD_W      = NUM_W + MUL_W;
  localparam int LEVEL_SHIFT = 39;
  localparam logic [MUL_W-1:0] LEVEL_MUL = 28'd233646232;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE      = 2'd1;

  // Hue sectors, 60 degrees each.
  localparam logic [SEC_W-1:0] SEC_RED_YELLOW   = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YELLOW_GREEN = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GREEN_CYAN   = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYAN_BLUE    = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLUE_MAGENTA = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAGENTA_RED  = 3'd5;

  typedef struct packed {
    logic             valid;
    logic [SEC_W-1:0] sector;
    logic [FR_W-1:0]  fr;
  } hsv_sec_t;

  typedef struct packed {
    logic              valid;
    logic [TERM_W-1:0] r;
    logic [TERM_W-1:0] g;
    logic [TERM_W-1:0] b;
  } hsv_term_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] g;
    logic [NUM_W-1:0] b;
  } hsv_num_t;

endpackage

/* hw/rtl/hsv_sector.sv */
// First stage: splits the hue into its sector and the offset inside it.
module hsv_sector (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [hsv_pkg::HUE_W-1:0] hue_deg,
  output hsv_pkg::hsv_sec_t        sec_o
);

  hsv_pkg::hsv_sec_t sec_r;
  hsv_pkg::hsv_sec_t sec_nxt;
  logic [3:0]                 step;
  logic [hsv_pkg::HUE_W-1:0]  base;

  // The boundary compares are independent; the highest one passed wins.
  always_comb begin
    step = '0;
    for (int i = 1; i <= hsv_pkg::HUE_STEPS; i++) begin
      if (hue_deg >= hsv_pkg::HUE_W'(i * hsv_pkg::SECTOR_DEG)) begin
        step = 4'(i);
      end
    end
    base           = hsv_pkg::HUE_W'(int'(step) * hsv_pkg::SECTOR_DEG);
    sec_nxt.valid  = accept;
    sec_nxt.fr     = hsv_pkg::FR_W'(hue_deg - base);
    sec_nxt.sector = (step >= 4'(hsv_pkg::SECTOR_COUNT)) ?
                     hsv_pkg::SEC_W'(step - 4'(hsv_pkg::SECTOR_COUNT)) :
                     hsv_pkg::SEC_W'(step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r.valid <= 1'b0;
    end else begin
      sec_r <= sec_nxt;
    end
  end

  assign sec_o = sec_r;

endmodule

/* hw/rtl/hsv_terms.sv */
// Second stage: forms the saturation terms of V, p, q and t and routes them by sector.
module hsv_terms (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [hsv_pkg::PCT_W-1:0] sat_pct,
  input  hsv_pkg::hsv_sec_t         sec_i,
  output hsv_pkg::hsv_term_t        term_o
);

  hsv_pkg::hsv_term_t term_r;
  hsv_pkg::hsv_term_t term_nxt;
  logic [hsv_pkg::TERM_W-1:0] s_ext;
  logic [hsv_pkg::TERM_W-1:0] tv;
  logic [hsv_pkg::TERM_W-1:0] tp;
  logic [hsv_pkg::TERM_W-1:0] tq;
  logic [hsv_pkg::TERM_W-1:0] tt;

  always_comb begin
    s_ext = hsv_pkg::TERM_W'(sat_pct);
    tv    = hsv_pkg::TERM_W'(hsv_pkg::TERM_FULL);
    tp    = (hsv_pkg::TERM_W'(hsv_pkg::PCT_FULL) - s_ext) *
            hsv_pkg::TERM_W'(hsv_pkg::SECTOR_DEG);
    tq    = tv - hsv_pkg::TERM_W'(sec_i.fr) * s_ext;
    tt    = tv - (hsv_pkg::TERM_W'(hsv_pkg::SECTOR_DEG) -
                  hsv_pkg::TERM_W'(sec_i.fr)) * s_ext;

    term_nxt.valid = sec_i.valid;
    unique case (sec_i.sector)
      hsv_pkg::SEC_YELLOW_GREEN: begin
        term_nxt.r = tq; term_nxt.g = tv; term_nxt.b = tp;
      end
      hsv_pkg::SEC_GREEN_CYAN: begin
        term_nxt.r = tp; term_nxt.g = tv; term_nxt.b = tt;
      end
      hsv_pkg::SEC_CYAN_BLUE: begin
        term_nxt.r = tp; term_nxt.g = tq; term_nxt.b = tv;
      end
      hsv_pkg::SEC_BLUE_MAGENTA: begin
        term_nxt.r = tt; term_nxt.g = tp; term_nxt.b = tv;
      end
      hsv_pkg::SEC_MAGENTA_RED: begin
        term_nxt.r = tv; term_nxt.g = tp; term_nxt.b = tq;
      end
      default: begin
        term_nxt.r = tv; term_nxt.g = tt; term_nxt.b = tp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r.valid <= 1'b0;
    end else begin
      term_r <= term_nxt;
    end
  end

  assign term_o = term_r;

endmodule

/* hw/rtl/hsv_scale.sv */
// Third and fourth stages: scale by value, then map the exact fraction to an 8-bit level.
module hsv_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [hsv_pkg::PCT_W-1:0] val_pct,
  input  hsv_pkg::hsv_term_t        term_i,
  output logic                      out_valid,
  output logic [hsv_pkg::LVL_W-1:0] out_red,
  output logic [hsv_pkg::LVL_W-1:0] out_green,
  output logic [hsv_pkg::LVL_W-1:0] out_blue
);

  hsv_pkg::hsv_num_t num_r;
  hsv_pkg::hsv_num_t num_nxt;
  logic                      valid_r;
  logic [hsv_pkg::LVL_W-1:0] red_r;
  logic [hsv_pkg::LVL_W-1:0] green_r;
  logic [hsv_pkg::LVL_W-1:0] blue_r;
  logic [hsv_pkg::LVL_W-1:0] red_nxt;
  logic [hsv_pkg::LVL_W-1:0] green_nxt;
  logic [hsv_pkg::LVL_W-1:0] blue_nxt;
  logic [hsv_pkg::PROD_W-1:0] prod_r;
  logic [hsv_pkg::PROD_W-1:0] prod_g;
  logic [hsv_pkg::PROD_W-1:0] prod_b;

  always_comb begin
    num_nxt.valid = term_i.valid;
    num_nxt.r     = hsv_pkg::NUM_W'(val_pct) * hsv_pkg::NUM_W'(term_i.r);
    num_nxt.g     = hsv_pkg::NUM_W'(val_pct) * hsv_pkg::NUM_W'(term_i.g);
    num_nxt.b     = hsv_pkg::NUM_W'(val_pct) * hsv_pkg::NUM_W'(term_i.b);
  end

  // Reciprocal multiply: exact floor division for every numerator in range.
  always_comb begin
    prod_r    = hsv_pkg::PROD_W'(num_r.r) * hsv_pkg::PROD_W'(hsv_pkg::LEVEL_MUL);
    prod_g    = hsv_pkg::PROD_W'(num_r.g) * hsv_pkg::PROD_W'(hsv_pkg::LEVEL_MUL);
    prod_b    = hsv_pkg::PROD_W'(num_r.b) * hsv_pkg::PROD_W'(hsv_pkg::LEVEL_MUL);
    red_nxt   = prod_r[hsv_pkg::LEVEL_SHIFT +: hsv_pkg::LVL_W];
    green_nxt = prod_g[hsv_pkg::LEVEL_SHIFT +: hsv_pkg::LVL_W];
    blue_nxt  = prod_b[hsv_pkg::LEVEL_SHIFT +: hsv_pkg::LVL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r.valid <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      num_r   <= num_nxt;
      valid_r <= num_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

/* hw/rtl/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB converter: configuration registers and the four-stage pipeline.
// A hue word taken at a clock edge passes the sector, term, product and level registers in turn
// to the result ports, stays there for one cycle and is taken by the receiver in that cycle.
// Throughput: one hue word per clock; busy never rises, since every stage advances each cycle.
// The result strobe cannot be held off, so no stage ever waits on the receiver.
// Reset (synchronous, rst_n low) empties the pipeline and sets saturation and value to 100.
module hsv_to_rgb_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input word channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [hsv_pkg::HUE_W-1:0]     in_hue_deg,
  // Result word channel.
  output logic                          out_valid,
  output logic [hsv_pkg::LVL_W-1:0]     out_red,
  output logic [hsv_pkg::LVL_W-1:0]     out_green,
  output logic [hsv_pkg::LVL_W-1:0]     out_blue,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hsv_pkg::PCT_W-1:0]     cfg_data
);

  logic [hsv_pkg::PCT_W-1:0] sat_pct_r;
  logic [hsv_pkg::PCT_W-1:0] sat_pct_nxt;
  logic [hsv_pkg::PCT_W-1:0] val_pct_r;
  logic [hsv_pkg::PCT_W-1:0] val_pct_nxt;
  logic [hsv_pkg::PCT_W-1:0] cfg_clamped;
  logic                      in_accept;
  logic                      cfg_write;

  hsv_pkg::hsv_sec_t  sec;
  hsv_pkg::hsv_term_t term;

  // The pipeline takes a word every cycle, and register writes are always taken.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // Percentages above full scale are stored as full scale. Unknown indexes are dropped.
  always_comb begin
    cfg_clamped = (cfg_data > hsv_pkg::PCT_W'(hsv_pkg::PCT_FULL)) ?
                  hsv_pkg::PCT_W'(hsv_pkg::PCT_FULL) : cfg_data;
    sat_pct_nxt = sat_pct_r;
    val_pct_nxt = val_pct_r;
    if (cfg_write) begin
      unique case (cfg_index)
        hsv_pkg::REG_SATURATION: sat_pct_nxt = cfg_clamped;
        hsv_pkg::REG_VALUE:      val_pct_nxt = cfg_clamped;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_pct_r <= hsv_pkg::PCT_W'(hsv_pkg::PCT_FULL);
      val_pct_r <= hsv_pkg::PCT_W'(hsv_pkg::PCT_FULL);
    end else begin
      sat_pct_r <= sat_pct_nxt;
      val_pct_r <= val_pct_nxt;
    end
  end

  // Stage one finds the sector and the offset of the hue inside it.
  hsv_sector u_sector (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .hue_deg (in_hue_deg),
    .sec_o   (sec)
  );

  // Stage two applies saturation and picks which term feeds each channel.
  hsv_terms u_terms (
    .clk     (clk),
    .rst_n   (rst_n),
    .sat_pct (sat_pct_r),
    .sec_i   (sec),
    .term_o  (term)
  );

  // Stages three and four apply value and turn the exact fraction into a level.
  hsv_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .val_pct   (val_pct_r),
    .term_i    (term),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  // A result strobe only ever follows an accepted hue word.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("result strobe without a matching input word");

  // With zero value at the scaling stage, every channel comes out black.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(val_pct_r, 2) == '0)) |->
      (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("nonzero channel with zero value");

  // With zero saturation at the term stage, the color is a gray.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(sat_pct_r, 3) == '0)) |->
      (out_red == out_green && out_green == out_blue))
    else $error("channels differ with zero saturation");

  // Stored percentages never pass full scale.
  assert property (@(posedge clk) disable iff (!rst_n)
    (sat_pct_r <= hsv_pkg::PCT_W'(hsv_pkg::PCT_FULL)) &&
    (val_pct_r <= hsv_pkg::PCT_W'(hsv_pkg::PCT_FULL)))
    else $error("configuration percentage above full scale");

endmodule
